FILE: sv/cbm_pkg.sv
// Shared constants for the cartridge bank mapper: stream packing widths,
// register window codes, mapper command codes, update kinds, the lock data bit and the line step.
// No dependencies.
package cbm_pkg;

    // Stream word packing
    localparam int IN_TDATA_W  = 24;  // address[15:0], write_data[23:16]
    localparam int IN_TUSER_W  = 1;   // command[0]
    localparam int OUT_TDATA_W = 16;  // bank_slot[2:0], bank_number[10:3], mirror_mode[12:11]
    localparam int OUT_TUSER_W = 4;   // update_kind[2:0], irq_pulse[3]

    // Input command: bus write or scanline tick
    localparam logic IN_BUS_WRITE = 1'b0;
    localparam logic IN_TICK      = 1'b1;

    // Register windows, address bits 15..13
    localparam logic [2:0] WIN_CMD  = 3'b100;
    localparam logic [2:0] WIN_EXEC = 3'b101;

    // Mapper commands
    localparam logic [3:0] CMD_CHR_FIRST = 4'd0;
    localparam logic [3:0] CMD_CHR_LAST  = 4'd7;
    localparam logic [3:0] CMD_LOW_PRG   = 4'd8;
    localparam logic [3:0] CMD_PRG_FIRST = 4'd9;
    localparam logic [3:0] CMD_PRG_LAST  = 4'd11;
    localparam logic [3:0] CMD_MIRROR    = 4'd12;
    localparam logic [3:0] CMD_IRQ_EN    = 4'd13;
    localparam logic [3:0] CMD_CNT_LO    = 4'd14;
    localparam logic [3:0] CMD_CNT_HI    = 4'd15;

    // Update kinds
    localparam logic [2:0] KIND_NONE    = 3'd0;
    localparam logic [2:0] KIND_CHR     = 3'd1;
    localparam logic [2:0] KIND_PRG     = 3'd2;
    localparam logic [2:0] KIND_LOW_PRG = 3'd3;
    localparam logic [2:0] KIND_MIRROR  = 3'd4;

    localparam int          DATA_LOCK_BIT = 6;
    localparam logic [15:0] LINE_STEP     = 16'd113;

endpackage

FILE: sv/cartridge_bank_mapper_irq.sv
// Cartridge bank mapper with scanline IRQ counter, top level.
// Decodes bus writes into bank updates and runs the interrupt counter.
// Depends on cbm_pkg.
//
// Usage:
//   Slave stream s_axis carries one word per bus write or scanline tick:
//   tuser[0] selects tick (1) or bus write (0); tdata holds the address
//   and the written byte. Every accepted word yields exactly one master
//   word on m_axis: tuser holds the update kind and the IRQ pulse, tdata
//   holds the bank slot, bank number and mirroring mode.
//   The lock register is written through i_cfg_we / i_cfg_wdata. The user
//   must write it only while the block is idle; the block itself does not
//   enforce this. An accepted word loads the input register and moves on
//   into the result register once that register is empty or being read;
//   the decode and the 16-bit counter compare/subtract sit between the two
//   registers, and mapper state updates as a word moves into the result
//   register. Throughput is one word per cycle while the receiver
//   does not stall. When the receiver stalls, the result holds and the
//   input register still takes one more word; after that s_axis_tready
//   drops. Synchronous active-low reset empties both stages, clears the
//   command latch, IRQ enable, counter and the lock register.
module cartridge_bank_mapper_irq (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic                               i_cfg_wdata,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // address[15:0], write_data[23:16]
    input  logic [cbm_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // command[0]
    input  logic [cbm_pkg::IN_TUSER_W-1:0]     s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // bank_slot[2:0], bank_number[10:3], mirror_mode[12:11], zero[15:13]
    output logic [cbm_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // update_kind[2:0], irq_pulse[3]
    output logic [cbm_pkg::OUT_TUSER_W-1:0]    m_axis_tuser
);
    import cbm_pkg::*;

    // Input stage
    logic        r_in_valid;
    logic        r_in_cmd;
    logic [15:0] r_in_addr;
    logic [7:0]  r_in_data;

    // Mapper state
    logic        r_lock;
    logic [3:0]  r_sel;
    logic        r_irq_en;
    logic [15:0] r_irq_count;

    // Result stage
    logic        r_out_valid;
    logic [2:0]  r_out_kind;
    logic [2:0]  r_out_slot;
    logic [7:0]  r_out_bank;
    logic [1:0]  r_out_mirror;
    logic        r_out_irq;

    logic        n_sel_unused;
    logic [3:0]  n_sel;
    logic        n_irq_en;
    logic [15:0] n_irq_count;
    logic [2:0]  n_kind;
    logic [2:0]  n_slot;
    logic [7:0]  n_bank;
    logic [1:0]  n_mirror;
    logic        n_irq;

    logic advance;
    logic step;
    logic fire;

    assign advance       = !r_out_valid || m_axis_tready;
    assign step          = r_in_valid && advance;
    assign s_axis_tready = !r_in_valid || advance;
    assign fire          = r_irq_en && (r_irq_count <= LINE_STEP);
    assign n_sel_unused  = 1'b0;

    always_comb begin
        n_sel       = r_sel;
        n_irq_en    = r_irq_en;
        n_irq_count = r_irq_count;
        n_kind      = KIND_NONE;
        n_slot      = 3'd0;
        n_bank      = 8'd0;
        n_mirror    = 2'd0;
        n_irq       = 1'b0;
        if (r_in_cmd == IN_TICK) begin
            if (r_irq_en) begin
                if (fire) begin
                    n_irq       = 1'b1;
                    n_irq_count = 16'd0;
                end else begin
                    n_irq_count = r_irq_count - LINE_STEP;
                end
            end
        end else begin
            case (r_in_addr[15:13])
                WIN_CMD: begin
                    n_sel = r_in_data[3:0];
                end
                WIN_EXEC: begin
                    case (r_sel) inside
                        [CMD_CHR_FIRST:CMD_CHR_LAST]: begin
                            n_kind = KIND_CHR;
                            n_slot = r_sel[2:0];
                            n_bank = r_in_data;
                        end
                        CMD_LOW_PRG: begin
                            // drop when locked or when the byte has bit DATA_LOCK_BIT set
                            if (!r_lock && !r_in_data[DATA_LOCK_BIT]) begin
                                n_kind = KIND_LOW_PRG;
                                n_bank = r_in_data;
                            end
                        end
                        [CMD_PRG_FIRST:CMD_PRG_LAST]: begin
                            n_kind = KIND_PRG;
                            n_slot = 3'(r_sel - CMD_PRG_FIRST);
                            n_bank = r_in_data;
                        end
                        CMD_MIRROR: begin
                            n_kind   = KIND_MIRROR;
                            n_mirror = r_in_data[1:0];
                        end
                        CMD_IRQ_EN: begin
                            n_irq_en = (r_in_data != 8'd0);
                        end
                        CMD_CNT_LO: begin
                            n_irq_count = {r_irq_count[15:8], r_in_data};
                        end
                        default: begin
                            n_irq_count = {r_in_data, r_irq_count[7:0]};
                        end
                    endcase
                end
                default: begin
                    n_sel = r_sel;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_lock      <= 1'b0;
            r_sel       <= 4'd0;
            r_irq_en    <= 1'b0;
            r_irq_count <= 16'd0;
        end else begin
            if (i_cfg_we) begin
                r_lock <= i_cfg_wdata;
            end
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
            if (step) begin
                r_sel       <= n_sel | {3'd0, n_sel_unused};
                r_irq_en    <= n_irq_en;
                r_irq_count <= n_irq_count;
            end
        end
    end

    // Payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (s_axis_tready) begin
            r_in_cmd  <= s_axis_tuser[0];
            r_in_addr <= s_axis_tdata[15:0];
            r_in_data <= s_axis_tdata[23:16];
        end
        if (step) begin
            r_out_kind   <= n_kind;
            r_out_slot   <= n_slot;
            r_out_bank   <= n_bank;
            r_out_mirror <= n_mirror;
            r_out_irq    <= n_irq;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'd0, r_out_mirror, r_out_bank, r_out_slot};
    assign m_axis_tuser  = {r_out_irq, r_out_kind};

    // A firing tick clears the counter and carries the pulse out
    a_fire_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && r_in_cmd == IN_TICK && fire) |=> (r_irq_count == 16'd0 && r_out_irq))
        else $error("firing tick did not clear counter or raise pulse");

    // An IRQ pulse only comes with a result of kind none
    a_pulse_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_irq) |-> (r_out_kind == KIND_NONE))
        else $error("irq pulse on a bank update");

    // A held input word is never overwritten or lost
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> (r_in_valid && $stable(r_in_addr) && $stable(r_in_data)))
        else $error("stalled input word lost");

    // Counter and enable change only when a word moves through
    a_state_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !step |=> ($stable(r_irq_count) && $stable(r_irq_en) && $stable(r_sel)))
        else $error("mapper state changed without a word");

endmodule
